### src/dbrk_pkg.sv
// ---------------------------------------------------------------------------
// dbrk_pkg: shared definitions for the distinct byte run key table
// Operation codes, search status codes and ring sizes used across the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbrk_pkg;

	// Byte and ring geometry.
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 2;
	localparam int RING_DEPTH = 256;
	localparam int SLOT_W     = $clog2(RING_DEPTH);

	// A window this long plus one new distinct byte completes a run.
	localparam logic [SLOT_W-1:0] FULL_LEN = SLOT_W'(RING_DEPTH - 1);

	// Operation codes carried with each input word.
	localparam logic [OP_W-1:0] OP_SCAN = 2'd0;
	localparam logic [OP_W-1:0] OP_END  = 2'd1;
	localparam logic [OP_W-1:0] OP_KEY  = 2'd2;

	// Search phase, reported directly as the status field.
	typedef enum logic [OP_W-1:0] {
		PH_SEARCH    = 2'd0,
		PH_FOUND     = 2'd1,
		PH_NOT_FOUND = 2'd2
	} phase_t;

endpackage

`default_nettype wire

### src/distinct_byte_run_key_table.sv
// Each accepted word passes stage 1, stage 2 and the output register.
// Throughput: one input word per cycle unless the output stalls; the ring
// bounds update in the last stage, and forwarding covers back-to-back bytes.
// Reset (arst_n low, asynchronous): search restarts, window empty, all seen
// bits cleared; the two RAMs are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// distinct_byte_run_key_table: first run of 256 distinct bytes, key lookup
// A three-step pipeline (RAM read, RAM read, update) around two synchronous
// RAMs holding the last slot of each value and the byte in each ring slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distinct_byte_run_key_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [dbrk_pkg::OP_W-1:0]    op,
	input  wire logic [dbrk_pkg::BYTE_W-1:0]  data_byte,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [dbrk_pkg::OP_W-1:0]    search_status,
	output logic      [dbrk_pkg::BYTE_W-1:0]  key_value
);

	import dbrk_pkg::*;

	// The whole pipeline moves together whenever the output register can
	// take a new word. The stall reaches the input combinationally, so a new
	// word is accepted in the same cycle a waiting result is taken.
	logic adv;
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	// Stage 1 holds the word whose last-slot read data is arriving from the
	// RAM. Stage 2 holds the word whose window byte read data is arriving and
	// where the ring bounds and search phase are updated.
	logic              v_s1, v_s2;
	logic [OP_W-1:0]   op_s1, op_s2;
	logic [BYTE_W-1:0] byte_s1, byte_s2;
	logic [SLOT_W-1:0] slot_s2;

	// Ring bounds, phase and the per-value seen bits.
	logic [SLOT_W-1:0]     head_q, tail_q;
	phase_t                phase_q;
	logic [RING_DEPTH-1:0] seen_q;

	// The RAM write from the previous pipeline advance. A read issued on the
	// same edge as a write returns old data, so these registers patch it.
	logic              lfw_en_q;
	logic [BYTE_W-1:0] lfw_addr_q;
	logic [SLOT_W-1:0] lfw_data_q;
	logic              wfw_en_q;
	logic [SLOT_W-1:0] wfw_addr_q;
	logic [BYTE_W-1:0] wfw_data_q;

	logic [SLOT_W-1:0] l_rdata;
	logic [BYTE_W-1:0] w_rdata;

	// Stage 2 writes both RAMs for every scanned byte while the search runs.
	logic wr_s2;
	logic mem_we;
	assign wr_s2  = v_s2 && (op_s2 == OP_SCAN) && (phase_q == PH_SEARCH);
	assign mem_we = wr_s2 && adv;

	// ---------------------------------------------------------------------
	// Stage 1: resolve the last slot of the byte. The word now in stage 2 has
	// not written yet, and the write of the advance before was missed by the
	// read, so both are checked, the younger first.
	// ---------------------------------------------------------------------
	logic [SLOT_W-1:0] slot_s1;

	always_comb begin
		slot_s1 = l_rdata;
		if (wr_s2 && (byte_s2 == byte_s1)) begin
			slot_s1 = tail_q;
		end else if (lfw_en_q && (lfw_addr_q == byte_s1)) begin
			slot_s1 = lfw_data_q;
		end
	end

	dbrk_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(RING_DEPTH)
	) u_last_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(byte_s2),
		.wdata(tail_q),
		.re   (adv),
		.raddr(data_byte),
		.rdata(l_rdata)
	);

	dbrk_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_DEPTH)
	) u_window_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(tail_q),
		.wdata(byte_s2),
		.re   (adv),
		.raddr(slot_s1),
		.rdata(w_rdata)
	);

	// ---------------------------------------------------------------------
	// Stage 2: decide whether the byte repeats one inside the window. The
	// earlier copy counts only if its slot lies between head and tail and
	// still holds this value; a slot reused by another value does not count.
	// ---------------------------------------------------------------------
	logic [BYTE_W-1:0] wbyte_s2;
	logic [SLOT_W-1:0] win_len;
	logic [SLOT_W-1:0] slot_off;
	logic              hit;
	logic [SLOT_W-1:0] head_d, tail_d;
	phase_t            phase_d;
	logic [BYTE_W-1:0] key_d;

	assign wbyte_s2 = (wfw_en_q && (wfw_addr_q == slot_s2)) ? wfw_data_q : w_rdata;
	assign win_len  = tail_q - head_q;
	assign slot_off = slot_s2 - head_q;
	assign hit      = seen_q[byte_s2] && (slot_off < win_len) && (wbyte_s2 == byte_s2);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		phase_d = phase_q;
		key_d   = '0;
		case (op_s2)
			OP_SCAN: begin
				if (phase_q == PH_SEARCH) begin
					if (!hit && (win_len == FULL_LEN)) begin
						phase_d = PH_FOUND;
					end else begin
						if (hit) begin
							head_d = slot_s2 + SLOT_W'(1);
						end
						tail_d = tail_q + SLOT_W'(1);
					end
				end
			end
			OP_END: begin
				if (phase_q == PH_SEARCH) begin
					phase_d = PH_NOT_FOUND;
				end
			end
			OP_KEY: begin
				// Once the run is found, every value's last slot lies in it.
				if (phase_q == PH_FOUND) begin
					key_d = slot_s2 - head_q;
				end else begin
					key_d = byte_s2;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Control registers: stage valids, ring state, forwarding enables.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			phase_q      <= PH_SEARCH;
			seen_q       <= '0;
			lfw_en_q     <= 1'b0;
			wfw_en_q     <= 1'b0;
		end else if (adv) begin
			v_s1         <= item_valid;
			v_s2         <= v_s1;
			result_valid <= v_s2;
			lfw_en_q     <= mem_we;
			wfw_en_q     <= mem_we;
			if (v_s2) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				phase_q <= phase_d;
			end
			if (mem_we) begin
				seen_q[byte_s2] <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1         <= op;
			byte_s1       <= data_byte;
			op_s2         <= op_s1;
			byte_s2       <= byte_s1;
			slot_s2       <= slot_s1;
			lfw_addr_q    <= byte_s2;
			lfw_data_q    <= tail_q;
			wfw_addr_q    <= tail_q;
			wfw_data_q    <= byte_s2;
			search_status <= phase_d;
			key_value     <= key_d;
		end
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_found_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FOUND) |=> (phase_q == PH_FOUND))
		else $error("search phase left the run-found state");

	a_ring_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_SEARCH) |=> ($stable(head_q) && $stable(tail_q)))
		else $error("ring bounds moved after the search ended");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s2))
		else $error("result word appeared without an item in the last stage");

endmodule

`default_nettype wire

### src/dbrk_ram.sv
// ---------------------------------------------------------------------------
// dbrk_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and held while
// the read enable is low. A read of the address being written returns the
// old contents.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbrk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### dv/tb_distinct_byte_run_key_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_distinct_byte_run_key_table: self-checking bench for the run key table
// Drives scan, end and key-read words through the valid/stall handshake,
// predicts each result word with a behavioral copy of the run search, and
// compares every returned word field by field in order of arrival.
// ---------------------------------------------------------------------------

module tb_distinct_byte_run_key_table;

	import dbrk_pkg::*;

	// The op field has one code that the block does not use. It must still be
	// accepted and answered with the current status and a zero key.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int RESET_CYCLES   = 11;
	localparam int HOLD_CYCLES    = 60;    // one long receiver hold-off
	localparam int HOLD_AFTER     = 10;    // results seen before the hold-off
	localparam int DRAIN_CYCLES   = 8;     // extra cycles watched for stray result words
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
	localparam int MODE_SPAN      = 50;    // input words per idling mode
	localparam int DIRECTED_ROWS  = 20;

	// Idling modes, stepped through in this order as words are sent.
	typedef enum int {
		MODE_NONE,
		MODE_RECV,
		MODE_SEND,
		MODE_BOTH
	} idle_mode_t;

	// One result word: the search status and the key of the byte read.
	typedef struct packed {
		logic [OP_W-1:0]   status;
		logic [BYTE_W-1:0] key;
	} lookup_t;

	// One row of directed stimulus. Where typed is set, the expected result
	// is the one written in the row; otherwise the predictor supplies it.
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] value;
		bit                typed;
		lookup_t           result;
	} directed_row_t;

	// Clock and reset. The clock runs from time zero; reset is held low for
	// a fixed number of cycles and then released once, at a rising edge.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// Every input of the block starts at a known value.
	logic              item_valid   = 1'b0;
	logic [OP_W-1:0]   op           = OP_SCAN;
	logic [BYTE_W-1:0] data_byte    = '0;
	logic              result_stall = 1'b0;
	logic              item_stall;
	logic              result_valid;
	logic [OP_W-1:0]   search_status;
	logic [BYTE_W-1:0] key_value;

	distinct_byte_run_key_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.data_byte     (data_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.search_status (search_status),
		.key_value     (key_value)
	);

	// -----------------------------------------------------------------------
	// Predictor of the run search.
	// The window of distinct bytes lives in a 256-slot ring between
	// ring_head and ring_tail. slot_of_value remembers where each value was
	// last written, and value_written tells whether that entry is valid.
	// -----------------------------------------------------------------------
	logic [BYTE_W-1:0] ring_byte     [RING_DEPTH];
	logic [BYTE_W-1:0] slot_of_value [RING_DEPTH];
	bit                value_written [RING_DEPTH];
	logic [BYTE_W-1:0] ring_head;
	logic [BYTE_W-1:0] ring_tail;
	phase_t            search_phase;

	// Result words still owed by the block, oldest first.
	lookup_t pending_lookups [$];

	int         mismatches   = 0;
	int         words_sent   = 0;
	int         results_seen = 0;
	int         quiet_cycles = 0;
	idle_mode_t idle_mode    = MODE_NONE;

	// Directed rows. Everything here happens while the search is still
	// running, so status stays at searching and key reads give the byte back.
	// Scans of repeated bytes are left to the predictor, since they move the
	// window in ways that are not obvious from the row alone.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_KEY,   8'h00, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_KEY,   8'hFF, 1'b1, '{PH_SEARCH, 8'hFF}},
		'{OP_SPARE, 8'hFF, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h00, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'hFF, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h00, 1'b0, '{PH_SEARCH, 8'h00}},
		'{OP_KEY,   8'h00, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h55, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'hAA, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h55, 1'b0, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h80, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h01, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h01, 1'b0, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h7F, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'hFF, 1'b0, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h00, 1'b0, '{PH_SEARCH, 8'h00}},
		'{OP_KEY,   8'hA5, 1'b1, '{PH_SEARCH, 8'hA5}},
		'{OP_KEY,   8'h5A, 1'b1, '{PH_SEARCH, 8'h5A}},
		'{OP_SPARE, 8'h00, 1'b1, '{PH_SEARCH, 8'h00}},
		'{OP_SCAN,  8'h80, 1'b0, '{PH_SEARCH, 8'h00}}
	};

	// Scans one byte into the window. A byte already in the window cuts the
	// window just past its earlier copy. A byte new to a window that already
	// holds 255 bytes completes the run, and the tail stays where it is.
	function automatic void scan_window(input logic [BYTE_W-1:0] value);
		logic [BYTE_W-1:0] length;
		logic [BYTE_W-1:0] offset;
		logic [BYTE_W-1:0] slot;
		logic              repeat_hit;
		length     = ring_tail - ring_head;
		repeat_hit = 1'b0;
		slot       = '0;
		if (value_written[value]) begin
			slot       = slot_of_value[value];
			offset     = slot - ring_head;
			repeat_hit = (offset < length) && (ring_byte[slot] == value);
		end
		ring_byte[ring_tail] = value;
		slot_of_value[value] = ring_tail;
		value_written[value] = 1'b1;
		if (!repeat_hit && length == FULL_LEN) begin
			search_phase = PH_FOUND;
			return;
		end
		if (repeat_hit)
			ring_head = slot + 8'd1;
		ring_tail = ring_tail + 8'd1;
	endfunction

	// Applies one input word to the predictor and returns the result word.
	function automatic lookup_t run_lookup(input logic [OP_W-1:0] code,
			input logic [BYTE_W-1:0] value);
		lookup_t word;
		word.key = '0;
		case (code)
			OP_SCAN: begin
				if (search_phase == PH_SEARCH)
					scan_window(value);
			end
			OP_END: begin
				if (search_phase == PH_SEARCH)
					search_phase = PH_NOT_FOUND;
			end
			OP_KEY: begin
				// Once a run is found, the key is the byte's place in it.
				if (search_phase == PH_FOUND)
					word.key = slot_of_value[value] - ring_head;
				else
					word.key = value;
			end
			default: begin
			end
		endcase
		word.status = search_phase;
		return word;
	endfunction

	// -----------------------------------------------------------------------
	// Input side. A word is offered after an optional random gap, held until
	// the block takes it, and its expected result is queued at that edge.
	// Valid is decided before the edge and never looks at the stall.
	// -----------------------------------------------------------------------
	task automatic drive_word(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] value,
			input bit typed = 1'b0, input lookup_t typed_result = '0);
		int      gap_pct;
		lookup_t predicted;
		gap_pct = (idle_mode == MODE_SEND) ? 80 : (idle_mode == MODE_BOTH) ? 24 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= code;
		data_byte  <= value;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		// The predictor always runs so that its state tracks the block, even
		// when the row carries its own expected result.
		predicted = run_lookup(code, value);
		pending_lookups.push_back(typed ? typed_result : predicted);
		words_sent++;
		idle_mode = idle_mode_t'((words_sent / MODE_SPAN) % 4);
	endtask

	// Random mix used while the search is running: mostly scans, some key
	// reads, a few words with the unused code. Half the bytes come from a
	// narrow range so that repeats, and thus window cuts, are frequent.
	task automatic drive_searching_noise(input int count);
		int                r;
		logic [BYTE_W-1:0] value;
		repeat (count) begin
			r     = $urandom_range(0, 99);
			value = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 15))
				: BYTE_W'($urandom_range(0, 255));
			if (r < 65)
				drive_word(OP_SCAN, value);
			else if (r < 90)
				drive_word(OP_KEY, value);
			else
				drive_word(OP_SPARE, value);
		end
	endtask

	// Scans a run of distinct bytes in shuffled order. With cut set, the run
	// is broken by repeating one of its own bytes afterwards.
	task automatic drive_distinct_run(input int count, input bit cut);
		logic [BYTE_W-1:0] order [RING_DEPTH];
		logic [BYTE_W-1:0] swap;
		int                j;
		for (int i = 0; i < RING_DEPTH; i++)
			order[i] = i[BYTE_W-1:0];
		for (int i = RING_DEPTH - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			swap     = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < count; i++)
			drive_word(OP_SCAN, order[i]);
		if (cut)
			drive_word(OP_SCAN, order[$urandom_range(0, count - 1)]);
	endtask

	// Random mix once the search has ended: mostly key reads, plus scans and
	// end words that the block must ignore, and the unused code.
	task automatic drive_after_search(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				drive_word(OP_KEY, BYTE_W'($urandom_range(0, 255)));
			else if (r < 80)
				drive_word(OP_SCAN, BYTE_W'($urandom_range(0, 255)));
			else if (r < 92)
				drive_word(OP_END, BYTE_W'($urandom_range(0, 255)));
			else
				drive_word(OP_SPARE, BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	// -----------------------------------------------------------------------
	// Output side. The receiver stalls at random according to the idling
	// mode, and once early in the run holds off for a long stretch so that
	// the block fills up and pushes back on its input.
	// -----------------------------------------------------------------------
	int hold_left = 0;
	bit held_once = 1'b0;

	always @(posedge clk) begin
		int stall_pct;
		stall_pct = (idle_mode == MODE_RECV) ? 80 : (idle_mode == MODE_BOTH) ? 24 : 0;
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (!held_once && results_seen >= HOLD_AFTER) begin
			held_once    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Each result word taken by the receiver is checked against the oldest
	// expectation. A word with nothing outstanding is a failure by itself.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen <= results_seen + 1;
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual status %0d key %0d",
					$time, search_status, key_value);
				mismatches++;
			end else begin
				want = pending_lookups.pop_front();
				if (search_status !== want.status) begin
					$display("%0t: search_status expected %0d actual %0d",
						$time, want.status, search_status);
					mismatches++;
				end
				if (key_value !== want.key) begin
					$display("%0t: key_value expected %0d actual %0d",
						$time, want.key, key_value);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: counts cycles out of reset in which no word moves on either
	// side, and ends the run as a failure when the count reaches its limit.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Main sequence.
	// Reset is applied once, so the search can end only one way per run. Most
	// runs complete a run of 256 distinct bytes and then read keys; about one
	// run in four instead ends the data just short of a run and checks the
	// not-found behavior.
	// -----------------------------------------------------------------------
	initial begin
		bit complete_run;
		complete_run = ($urandom_range(0, 3) != 0);

		ring_head    = '0;
		ring_tail    = '0;
		search_phase = PH_SEARCH;
		for (int i = 0; i < RING_DEPTH; i++)
			value_written[i] = 1'b0;

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: identity reads, the unused code, extreme bytes and
		// repeats both of the newest byte and of one deeper in the window.
		foreach (directed_rows[i])
			drive_word(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].result);

		// Random search traffic, then a few short runs of distinct bytes that
		// are each broken by a repeat from inside the run.
		drive_searching_noise(80);
		repeat (3)
			drive_distinct_run($urandom_range(15, 40), 1'b1);

		if (complete_run) begin
			// A shuffled full set of byte values always finishes the run,
			// possibly early if it joins distinct bytes already in the window.
			drive_distinct_run(RING_DEPTH, 1'b0);
			// End of data after the run is found changes nothing.
			drive_word(OP_END, 8'h00);
			drive_word(OP_KEY, 8'h00);
			drive_word(OP_KEY, 8'hFF);
		end else begin
			// Scan 200 to 254 distinct bytes, break the run, then end the data.
			drive_distinct_run($urandom_range(200, 254), 1'b1);
			drive_word(OP_END, 8'hFF);
			drive_word(OP_END, 8'h00);
			drive_word(OP_KEY, 8'hFF);
		end
		drive_after_search(100);
		item_valid <= 1'b0;

		// Let the block return every word it owes, then watch a few more
		// cycles for stray result words.
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
